/* hdl/mcc_pkg.sv */
// Package for the magnetometer calibration conditioner.
// Beat types, command and register codes, reset values. No dependencies.
`default_nettype none

package mcc_pkg;

    // Command codes carried in the kind field
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_LIM  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN = 3'd7;

    // Register reset values
    localparam logic [15:0] SCALE_RST    = 16'd4096;
    localparam logic [7:0]  BAD_LIM_RST  = 8'd8;
    localparam logic [15:0] MIN_SPAN_RST = 16'd600;

    // Sample screening and extremes
    localparam logic signed [15:0] ABS_LIMIT = 16'sd32000;
    localparam logic signed [15:0] AXIS_MIN_RST = 16'sh7FFF;
    localparam logic signed [15:0] AXIS_MAX_RST = 16'sh8000;

    localparam int MIN_SAMPLES_DEF = 60;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
    } t_mag_in;

    typedef struct packed {
        logic signed [15:0] corrected_x;
        logic signed [15:0] corrected_y;
        logic signed [15:0] corrected_z;
        logic               accepted;
        logic               bad_sample;
        logic               restart_request;
        logic               collecting;
        logic               coverage_ok;
        logic [15:0]        collected_count;
        logic               dirty;
    } t_mag_out;

endpackage

`default_nettype wire

/* hdl/magnetometer_calibration_conditioner.sv */
// Magnetometer calibration conditioner, top level.
// Depends on mcc_pkg for beat types, codes and reset values.
//
// Usage:
//   Input channel (i_valid / o_stall / i_data): one beat is either a raw
//   three-axis sample (kind = sample) or a collection command (start or
//   cancel). Output channel (o_valid / i_stall / o_data): exactly one
//   result beat per input beat, in order.
//   Config port (i_cfg_we / i_cfg_index / i_cfg_data): plain write, one
//   register per clock, meant to be used only while the block is idle.
//   Path: input register, compute stage, result register driving o_valid.
//   Throughput: one beat per cycle while i_stall stays low; the state
//   loop (bad count, extremes, tally) closes in the single compute stage,
//   so back-to-back samples see each other's updates with no bubble.
//   Compute stage: per-axis offset subtract and 17x16 multiply, rounding
//   and saturation, plus min/max update and coverage compare.
//   Stall: a valid result register holds while i_stall is high; the input
//   register still takes one more beat, after which o_stall rises.
//   Reset (i_rst_n low, synchronous): pipeline empties, registers take
//   their defaults, collection stops, extremes return to their rails.
`default_nettype none

module magnetometer_calibration_conditioner #(
    parameter int MIN_SAMPLES = mcc_pkg::MIN_SAMPLES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input channel
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  mcc_pkg::t_mag_in                       i_data,
    // output channel
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output mcc_pkg::t_mag_out                      o_data,
    // config port
    input  wire logic                              i_cfg_we,
    input  wire logic [mcc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [mcc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mcc_pkg::*;

    // round_half_away((2*raw - off) * scale / 8192), saturated to int16
    function automatic logic signed [15:0] correct_axis(
        input logic signed [15:0] raw,
        input logic signed [16:0] off,
        input logic [15:0]        scale
    );
        logic signed [17:0] diff;
        logic [16:0]        mag;
        logic [32:0]        prod;
        logic [20:0]        q;
        logic signed [15:0] res;
        diff = $signed({raw[15], raw, 1'b0}) - $signed({off[16], off});
        mag  = diff[17] ? 17'(-diff) : diff[16:0];
        prod = 33'(mag) * 33'(scale);
        q    = 21'((prod + 33'd4096) >> 13);
        if (diff[17]) begin
            res = (q > 21'd32768) ? 16'sh8000 : 16'(-q);
        end else begin
            res = (q > 21'd32767) ? 16'sh7FFF : 16'(q);
        end
        return res;
    endfunction

    // config registers
    logic signed [16:0] r_offset [3];
    logic [15:0]        r_scale [3];
    logic [7:0]         r_bad_lim;
    logic [15:0]        r_min_span;

    // block state
    logic [7:0]         r_bad_count, n_bad_count;
    logic               r_collect, n_collect;
    logic               r_dirty, n_dirty;
    logic [15:0]        r_tally, n_tally;
    logic signed [15:0] r_min [3];
    logic signed [15:0] r_max [3];
    logic signed [15:0] n_min [3];
    logic signed [15:0] n_max [3];

    // pipeline
    logic     r_in_valid;
    t_mag_in  r_in;
    logic     r_out_valid;
    t_mag_out r_out, n_out;

    logic out_free, adv;

    // scratch for the compute stage
    logic signed [15:0] raw [3];
    logic signed [15:0] corr [3];
    logic signed [16:0] span_d [3];
    logic [2:0]         span_ok;
    logic               all_zero, all_large, is_bad;
    logic [7:0]         bad_inc;

    assign out_free = !r_out_valid || !i_stall;
    assign adv      = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    assign raw[0] = r_in.mag_x;
    assign raw[1] = r_in.mag_y;
    assign raw[2] = r_in.mag_z;

    always_comb begin
        all_zero  = (raw[0] == '0) && (raw[1] == '0) && (raw[2] == '0);
        all_large = 1'b1;
        for (int a = 0; a < 3; a++) begin
            all_large = all_large && (raw[a] >= ABS_LIMIT || raw[a] <= -ABS_LIMIT);
            corr[a]   = correct_axis(raw[a], r_offset[a], r_scale[a]);
        end
        is_bad  = all_zero || all_large;
        bad_inc = (r_bad_count == 8'hFF) ? r_bad_count : r_bad_count + 8'd1;

        n_bad_count = r_bad_count;
        n_collect   = r_collect;
        n_dirty     = r_dirty;
        n_tally     = r_tally;
        for (int a = 0; a < 3; a++) begin
            n_min[a] = r_min[a];
            n_max[a] = r_max[a];
        end
        n_out = '0;

        case (r_in.kind)
            KIND_SAMPLE: begin
                if (is_bad) begin
                    n_out.bad_sample = 1'b1;
                    // limit of zero also trips here on every bad sample
                    if (bad_inc >= r_bad_lim) begin
                        n_out.restart_request = 1'b1;
                        n_bad_count           = '0;
                    end else begin
                        n_bad_count = bad_inc;
                    end
                end else begin
                    n_out.accepted    = 1'b1;
                    n_out.corrected_x = corr[0];
                    n_out.corrected_y = corr[1];
                    n_out.corrected_z = corr[2];
                    n_bad_count       = '0;
                    if (r_collect) begin
                        for (int a = 0; a < 3; a++) begin
                            if (raw[a] < r_min[a]) n_min[a] = raw[a];
                            if (raw[a] > r_max[a]) n_max[a] = raw[a];
                        end
                        if (r_tally != 16'hFFFF) n_tally = r_tally + 16'd1;
                        n_dirty = 1'b1;
                    end
                end
            end
            KIND_START: begin
                n_collect = 1'b1;
                n_dirty   = 1'b0;
                n_tally   = '0;
                for (int a = 0; a < 3; a++) begin
                    n_min[a] = AXIS_MIN_RST;
                    n_max[a] = AXIS_MAX_RST;
                end
            end
            KIND_CANCEL: begin
                n_collect = 1'b0;
                n_dirty   = 1'b0;
                n_tally   = '0;
            end
            default: begin
                // unused code: no state change, no accepted, bad or restart flag
            end
        endcase

        // coverage is judged on the state after this beat
        for (int a = 0; a < 3; a++) begin
            span_d[a]  = 17'(n_max[a]) - 17'(n_min[a]);
            span_ok[a] = span_d[a] >= $signed({1'b0, r_min_span});
        end
        n_out.coverage_ok     = (n_tally >= 16'(MIN_SAMPLES)) && (&span_ok);
        n_out.collecting      = n_collect;
        n_out.collected_count = n_tally;
        n_out.dirty           = n_dirty;
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_offset[a] <= '0;
                r_scale[a]  <= SCALE_RST;
            end
            r_bad_lim  <= BAD_LIM_RST;
            r_min_span <= MIN_SPAN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OFFSET_X: r_offset[0] <= $signed(i_cfg_data);
                CFG_OFFSET_Y: r_offset[1] <= $signed(i_cfg_data);
                CFG_OFFSET_Z: r_offset[2] <= $signed(i_cfg_data);
                CFG_SCALE_X:  r_scale[0]  <= i_cfg_data[15:0];
                CFG_SCALE_Y:  r_scale[1]  <= i_cfg_data[15:0];
                CFG_SCALE_Z:  r_scale[2]  <= i_cfg_data[15:0];
                CFG_BAD_LIM:  r_bad_lim   <= i_cfg_data[7:0];
                CFG_MIN_SPAN: r_min_span  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline control and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_bad_count <= '0;
            r_collect   <= 1'b0;
            r_dirty     <= 1'b0;
            r_tally     <= '0;
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= AXIS_MIN_RST;
                r_max[a] <= AXIS_MAX_RST;
            end
        end else begin
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_bad_count <= n_bad_count;
                r_collect   <= n_collect;
                r_dirty     <= n_dirty;
                r_tally     <= n_tally;
                for (int a = 0; a < 3; a++) begin
                    r_min[a] <= n_min[a];
                    r_max[a] <= n_max[a];
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) r_in <= i_data;
        if (adv) r_out <= n_out;
    end

    // checks
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_out.restart_request |=> r_bad_count == '0)
        else $error("bad count not cleared after restart");

    a_acc_bad_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.accepted && o_data.bad_sample))
        else $error("beat both accepted and bad");

    a_tally_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.collecting || o_data.collected_count == '0)
        else $error("tally nonzero outside collection");

    a_stall_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in))
        else $error("input register lost a beat");

endmodule

`default_nettype wire

/* test/tb_magnetometer_calibration_conditioner.sv */
// Testbench for magnetometer_calibration_conditioner: directed table, then random beats
// under several register settings; checked by an in-bench predictor or typed-in results.
// Depends on mcc_pkg and the DUT only; self-checking, no files or arguments.
`default_nettype none

module tb_magnetometer_calibration_conditioner;
    timeunit 1ns;
    timeprecision 1ps;

    import mcc_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;  // no-op kind, must change nothing
    localparam int STALL_LIMIT  = 5000;         // cycles with no beat moving on either side
    localparam int RANDOM_BEATS = 125;          // per register setting
    localparam int MAX_PRINTS   = 50;

    typedef enum {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_OFF} t_idle_mode;

    typedef struct {
        t_mag_in  beat;
        bit       fixed;  // result typed in by hand
        t_mag_out res;
    } t_dir_row;

    typedef struct {
        bit       fixed;
        t_mag_out res;
    } t_pin;

    // DUT ports
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    t_mag_in                i_data = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    t_mag_out               o_data;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // predictor copy of the registers
    logic signed [16:0] off_half [3];
    logic [15:0]        gain_q12 [3];
    logic [7:0]         bad_limit;
    logic [15:0]        span_min;

    // predictor copy of the state
    logic [7:0]         bad_run;
    bit                 coll_on;
    bit                 coll_dirty;
    logic [15:0]        tally;
    logic signed [15:0] ax_lo [3];
    logic signed [15:0] ax_hi [3];

    t_mag_out calibrated_q [$];  // predicted result beats, oldest first
    t_pin     pinned_q [$];      // per driven beat: hand-typed result, if any
    t_dir_row dir_rows [$];

    int tx_pct = 0;
    int rx_pct = 0;
    int err_cnt = 0;
    int beats_sent = 0;
    int beats_out = 0;
    int idle_run = 0;
    int burst_left = 0;

    bit       took_in, took_out;
    t_mag_out model_out;
    t_pin     pin;

    magnetometer_calibration_conditioner i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void reset_extremes();
        int a;
        for (a = 0; a < 3; a++) begin
            ax_lo[a] = AXIS_MIN_RST;
            ax_hi[a] = AXIS_MAX_RST;
        end
    endfunction

    function automatic void pred_reset();
        int a;
        for (a = 0; a < 3; a++) begin
            off_half[a] = '0;
            gain_q12[a] = SCALE_RST;
        end
        bad_limit  = BAD_LIM_RST;
        span_min   = MIN_SPAN_RST;
        bad_run    = '0;
        coll_on    = 1'b0;
        coll_dirty = 1'b0;
        tally      = '0;
        reset_extremes();
    endfunction

    // (2*raw - offset) * gain / 8192, rounded half away from zero, clipped to int16
    function automatic logic signed [15:0] calib_axis(input logic signed [15:0] raw,
            input logic signed [16:0] off, input logic [15:0] gain);
        longint diff, mag, q, g;
        diff = 2 * longint'(raw) - longint'(off);
        g    = gain;
        mag  = (diff < 0 ? -diff : diff) * g;
        q    = (mag + 4096) >>> 13;
        if (diff < 0) begin
            if (q > 32768) q = 32768;
            return 16'(-q);
        end
        if (q > 32767) q = 32767;
        return 16'(q);
    endfunction

    function automatic bit is_large(input logic signed [15:0] v);
        return (v >= ABS_LIMIT) || (v <= -ABS_LIMIT);
    endfunction

    function automatic bit coverage_met();
        int a;
        if (tally < MIN_SAMPLES_DEF) return 1'b0;
        for (a = 0; a < 3; a++)
            if (int'(ax_hi[a]) - int'(ax_lo[a]) < int'(span_min)) return 1'b0;
        return 1'b1;
    endfunction

    // one accepted input beat -> its result beat; advances the predictor state
    function automatic t_mag_out calibrate_beat(input t_mag_in b);
        t_mag_out           r;
        logic signed [15:0] raw [3];
        bit                 all_zero, all_large;
        int                 a;
        r = '0;
        raw[0] = b.mag_x;
        raw[1] = b.mag_y;
        raw[2] = b.mag_z;
        case (b.kind)
            KIND_SAMPLE: begin
                all_zero  = (raw[0] == 0) && (raw[1] == 0) && (raw[2] == 0);
                all_large = is_large(raw[0]) && is_large(raw[1]) && is_large(raw[2]);
                if (all_zero || all_large) begin
                    r.bad_sample = 1'b1;
                    if (bad_run != 8'hFF) bad_run++;
                    if (bad_run >= bad_limit) begin
                        r.restart_request = 1'b1;
                        bad_run = '0;
                    end
                end else begin
                    r.accepted    = 1'b1;
                    bad_run       = '0;
                    r.corrected_x = calib_axis(raw[0], off_half[0], gain_q12[0]);
                    r.corrected_y = calib_axis(raw[1], off_half[1], gain_q12[1]);
                    r.corrected_z = calib_axis(raw[2], off_half[2], gain_q12[2]);
                    if (coll_on) begin
                        for (a = 0; a < 3; a++) begin
                            if (raw[a] < ax_lo[a]) ax_lo[a] = raw[a];
                            if (raw[a] > ax_hi[a]) ax_hi[a] = raw[a];
                        end
                        if (tally != 16'hFFFF) tally++;
                        coll_dirty = 1'b1;
                    end
                end
            end
            KIND_START: begin
                coll_on    = 1'b1;
                coll_dirty = 1'b0;
                tally      = '0;
                reset_extremes();
            end
            KIND_CANCEL: begin
                coll_on    = 1'b0;
                coll_dirty = 1'b0;
                tally      = '0;
            end
            default: ;
        endcase
        r.collecting      = coll_on;
        r.coverage_ok     = coverage_met();
        r.collected_count = tally;
        r.dirty           = coll_dirty;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
            $display("MISMATCH @%0t result beat %0d: %s", $time, beats_out, msg);
    endtask

    task automatic check_field(input string fld, input logic signed [31:0] got,
            input logic signed [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", fld, got, want));
    endtask

    task automatic check_beat(input t_mag_out got, input t_mag_out want);
        check_field("corrected_x", got.corrected_x, want.corrected_x);
        check_field("corrected_y", got.corrected_y, want.corrected_y);
        check_field("corrected_z", got.corrected_z, want.corrected_z);
        check_field("accepted", got.accepted, want.accepted);
        check_field("bad_sample", got.bad_sample, want.bad_sample);
        check_field("restart_request", got.restart_request, want.restart_request);
        check_field("collecting", got.collecting, want.collecting);
        check_field("coverage_ok", got.coverage_ok, want.coverage_ok);
        check_field("collected_count", got.collected_count, want.collected_count);
        check_field("dirty", got.dirty, want.dirty);
    endtask

    // Both channels are sampled here, at the edge, before any NBA lands.
    // Input side is handled first so a prediction always precedes its compare.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            took_in  = i_valid && !o_stall;
            took_out = o_valid && !i_stall;
            if (took_in) begin
                model_out = calibrate_beat(i_data);
                if (pinned_q.size() != 0) begin
                    pin = pinned_q.pop_front();
                    if (pin.fixed) model_out = pin.res;
                end
                calibrated_q.push_back(model_out);
            end
            if (took_out) begin
                beats_out++;
                if (calibrated_q.size() == 0)
                    report_mismatch("result beat with nothing pending");
                else
                    check_beat(o_data, calibrated_q.pop_front());
            end
            // watchdog: no progress on either channel for too long
            if (took_in || took_out) idle_run = 0;
            else idle_run++;
            if (idle_run >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_pct);
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    task automatic set_idle(input t_idle_mode m);
        case (m)
            IDLE_RX_HEAVY: begin tx_pct = 11; rx_pct = 86; end
            IDLE_TX_HEAVY: begin tx_pct = 86; rx_pct = 11; end
            default:       begin tx_pct = 0;  rx_pct = 0;  end
        endcase
    endtask

    // Called right after an edge; returns on the edge that takes the beat.
    task automatic send_beat(input t_mag_in b, input bit fixed, input t_mag_out res);
        t_pin p;
        while ($urandom_range(99) < tx_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        p.fixed = fixed;
        p.res   = res;
        pinned_q.push_back(p);
        i_valid <= 1'b1;
        i_data  <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (beats_out != beats_sent) @(posedge i_clk);
        repeat (4) @(posedge i_clk);  // pipeline is two deep, leave margin
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [16:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_OFFSET_X: off_half[0] = val;
            CFG_OFFSET_Y: off_half[1] = val;
            CFG_OFFSET_Z: off_half[2] = val;
            CFG_SCALE_X:  gain_q12[0] = val[15:0];
            CFG_SCALE_Y:  gain_q12[1] = val[15:0];
            CFG_SCALE_Z:  gain_q12[2] = val[15:0];
            CFG_BAD_LIM:  bad_limit   = val[7:0];
            CFG_MIN_SPAN: span_min    = val[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [16:0] ox, input logic [16:0] oy,
            input logic [16:0] oz, input logic [15:0] sx, input logic [15:0] sy,
            input logic [15:0] sz, input logic [7:0] lim, input logic [15:0] span);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_OFFSET_Z, oz);
        write_reg(CFG_SCALE_X, {1'b0, sx});
        write_reg(CFG_SCALE_Y, {1'b0, sy});
        write_reg(CFG_SCALE_Z, {1'b0, sz});
        write_reg(CFG_BAD_LIM, {9'd0, lim});
        write_reg(CFG_MIN_SPAN, {1'b0, span});
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    function automatic logic signed [15:0] pick_corner();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3:       return 16'sd1;
            4:       return -16'sd1;
            5:       return 16'sd31999;
            6:       return -16'sd31999;
            7:       return 16'sd32000;
            8:       return -16'sd32000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic signed [15:0] pick_axis();
        case ($urandom_range(9))
            0, 1, 2, 3: return 16'($urandom());
            4:          return pick_corner();
            default:    return 16'(int'($urandom_range(0, 8000)) - 4000);
        endcase
    endfunction

    // magnitude >= 32000, either sign, both rails included
    function automatic logic signed [15:0] pick_large();
        if ($urandom_range(1))
            return 16'(-32000 - int'($urandom_range(0, 768)));
        return 16'(32000 + int'($urandom_range(0, 767)));
    endfunction

    function automatic t_mag_in bad_beat();
        t_mag_in b;
        b.kind = KIND_SAMPLE;
        if ($urandom_range(1)) begin
            b.mag_x = '0;
            b.mag_y = '0;
            b.mag_z = '0;
        end else begin
            b.mag_x = pick_large();
            b.mag_y = pick_large();
            b.mag_z = pick_large();
        end
        return b;
    endfunction

    // Mostly samples inside long collections, with bad runs of random length,
    // the odd start/cancel and some no-op beats.
    function automatic t_mag_in next_random_beat();
        t_mag_in b;
        int      r;
        b.kind  = KIND_SAMPLE;
        b.mag_x = pick_axis();
        b.mag_y = pick_axis();
        b.mag_z = pick_axis();
        if (burst_left > 0) begin
            burst_left--;
            return bad_beat();
        end
        r = $urandom_range(999);
        if (r < 6) b.kind = KIND_START;
        else if (r < 10) b.kind = KIND_CANCEL;
        else if (r < 16) b.kind = KIND_UNUSED;
        else if (r < 36) begin
            burst_left = $urandom_range(0, int'(bad_limit) + 1);
            return bad_beat();
        end else if (r < 100) begin
            b.mag_x = pick_corner();
            b.mag_y = pick_corner();
            b.mag_z = pick_corner();
        end
        return b;
    endfunction

    task automatic run_random(input int n);
        int k;
        // open with a bad run long enough to hit the current limit
        for (k = 0; k <= int'(bad_limit); k++) send_beat(bad_beat(), 1'b0, '0);
        for (k = 0; k < n; k++) send_beat(next_random_beat(), 1'b0, '0);
    endtask

    function automatic t_mag_out mk_res(input int cx, input int cy, input int cz,
            input bit acc, input bit bad, input bit rst, input bit coll, input bit cov,
            input int cnt, input bit dirty);
        t_mag_out r;
        r.corrected_x     = 16'(cx);
        r.corrected_y     = 16'(cy);
        r.corrected_z     = 16'(cz);
        r.accepted        = acc;
        r.bad_sample      = bad;
        r.restart_request = rst;
        r.collecting      = coll;
        r.coverage_ok     = cov;
        r.collected_count = 16'(cnt);
        r.dirty           = dirty;
        return r;
    endfunction

    function automatic t_dir_row mk_row(input logic [1:0] kind, input int x, input int y,
            input int z, input bit fixed, input t_mag_out res);
        t_dir_row d;
        d.beat.kind  = kind;
        d.beat.mag_x = 16'(x);
        d.beat.mag_y = 16'(y);
        d.beat.mag_z = 16'(z);
        d.fixed      = fixed;
        d.res        = res;
        return d;
    endfunction

    // Runs with reset registers: unit gain, no offset, so corrected == raw.
    task automatic load_directed();
        t_mag_out only_bad;
        int       k;
        only_bad = mk_res(0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        // screening: all zero, all large on both rails, one axis just inside
        dir_rows.push_back(mk_row(KIND_SAMPLE, 0, 0, 0, 1, only_bad));
        dir_rows.push_back(mk_row(KIND_SAMPLE, 32767, -32768, 32000, 1, only_bad));
        dir_rows.push_back(mk_row(KIND_SAMPLE, -32000, 32000, -32000, 1, only_bad));
        dir_rows.push_back(mk_row(KIND_SAMPLE, 31999, 32767, 32767, 1,
            mk_res(31999, 32767, 32767, 1, 0, 0, 0, 0, 0, 0)));
        // unused kind: nothing moves
        dir_rows.push_back(mk_row(KIND_UNUSED, -1, -1, -1, 1, mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
        // collection: start, samples at the rails, cancel
        dir_rows.push_back(mk_row(KIND_START, 0, 0, 0, 1, mk_res(0, 0, 0, 0, 0, 0, 1, 0, 0, 0)));
        dir_rows.push_back(mk_row(KIND_SAMPLE, 32767, 1, -32768, 1,
            mk_res(32767, 1, -32768, 1, 0, 0, 1, 0, 1, 1)));
        dir_rows.push_back(mk_row(KIND_SAMPLE, -32768, -1, 32767, 1,
            mk_res(-32768, -1, 32767, 1, 0, 0, 1, 0, 2, 1)));
        dir_rows.push_back(mk_row(KIND_SAMPLE, 0, 0, 1, 1, mk_res(0, 0, 1, 1, 0, 0, 1, 0, 3, 1)));
        dir_rows.push_back(mk_row(KIND_CANCEL, 0, 0, 0, 1, mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(mk_row(KIND_SAMPLE, -1, -1, -1, 1,
            mk_res(-1, -1, -1, 1, 0, 0, 0, 0, 0, 0)));
        // eight bad in a row reach the reset limit, the count starts over
        for (k = 0; k < 7; k++) dir_rows.push_back(mk_row(KIND_SAMPLE, 0, 0, 0, 1, only_bad));
        dir_rows.push_back(mk_row(KIND_SAMPLE, 0, 0, 0, 1, mk_res(0, 0, 0, 0, 1, 1, 0, 0, 0, 0)));
        dir_rows.push_back(mk_row(KIND_SAMPLE, 0, 0, 0, 1, only_bad));
        // restart collection, near-threshold samples left to the predictor
        dir_rows.push_back(mk_row(KIND_START, 0, 0, 0, 1, mk_res(0, 0, 0, 0, 0, 0, 1, 0, 0, 0)));
        dir_rows.push_back(mk_row(KIND_SAMPLE, -32000, -32000, 31999, 0, '0));
        dir_rows.push_back(mk_row(KIND_SAMPLE, 32767, 32767, -31999, 0, '0));
        dir_rows.push_back(mk_row(KIND_CANCEL, 'h5A5A, 'hA5A5, 'hFFFF, 0, '0));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int p;
        pred_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idle(IDLE_RX_HEAVY);
        load_directed();
        foreach (dir_rows[k]) send_beat(dir_rows[k].beat, dir_rows[k].fixed, dir_rows[k].res);

        for (p = 1; p <= 8; p++) begin
            wait_drained();
            if (p >= 6) set_idle(IDLE_OFF);
            else if (p >= 3) set_idle(IDLE_TX_HEAVY);
            case (p)
                // most negative offset, largest nominal gain, limit 1, no span needed
                1: apply_setting(17'h10000, 17'h10000, 17'h10000,
                                 16'd32768, 16'd32768, 16'd32768, 8'd1, 16'd0);
                // most positive offset, zero gain, longest bad run, widest span
                2: apply_setting(17'h0FFFF, 17'h0FFFF, 17'h0FFFF,
                                 16'd0, 16'd0, 16'd0, 8'd255, 16'hFFFF);
                // zero limit: every bad sample restarts
                3: apply_setting(17'h00000, 17'h00000, 17'h00000,
                                 SCALE_RST, SCALE_RST, SCALE_RST, 8'd0, MIN_SPAN_RST);
                default: apply_setting(17'($urandom()), 17'($urandom()), 17'($urandom()),
                    ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768)),
                    ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768)),
                    ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768)),
                    $urandom_range(1) ? 8'($urandom_range(1, 12)) : 8'($urandom_range(1, 255)),
                    ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3000)));
            endcase
            run_random(RANDOM_BEATS);
        end

        wait_drained();
        if (calibrated_q.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived", calibrated_q.size()));
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* magnetometer_calibration_conditioner.f */
hdl/mcc_pkg.sv
hdl/magnetometer_calibration_conditioner.sv
test/tb_magnetometer_calibration_conditioner.sv
